FILE: hw/rtl/sib_pkg.sv
// ----------------------------------------------------------------------------
// sib_pkg
// Shared types and constants of the sample-in-ball challenge sampler.
// ----------------------------------------------------------------------------
package sib_pkg;

  localparam int NUM_COEFFS_DEF = 256;
  localparam int MODULUS_DEF    = 8380417;

  localparam int CMD_W    = 2;
  localparam int SIGN_W   = 64;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int COEFF_W  = 23;
  localparam int WEIGHT_W = 7;
  localparam int SCUR_W   = 6;
  localparam int CODE_W   = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 7'd39;
  localparam logic [WEIGHT_W-1:0] SIGN_CNT   = 7'd64;

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CODE_W-1:0] CODE_ZERO  = 2'd0;
  localparam logic [CODE_W-1:0] CODE_PLUS  = 2'd1;
  localparam logic [CODE_W-1:0] CODE_MINUS = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_STARTED  = 3'd0,
    ST_REJECTED = 3'd1,
    ST_ACCEPTED = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_READ     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_START,
    OP_BYTE,
    OP_READ,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [SIGN_W-1:0]   sign_word;
    logic [BYTE_W-1:0]   sample_byte;
    logic                ridx_ok;
    logic [BYTE_W-1:0]   read_index;
  } op_t;

endpackage

FILE: hw/rtl/sib_in_if.sv
// ----------------------------------------------------------------------------
// sib_in_if
// Command channel of the challenge sampler.
// ----------------------------------------------------------------------------
interface sib_in_if;
  logic                         valid;
  logic                         ready;
  logic [sib_pkg::CMD_W-1:0]    cmd;
  logic [sib_pkg::SIGN_W-1:0]   sign_word;
  logic [sib_pkg::BYTE_W-1:0]   sample_byte;
  logic [sib_pkg::BYTE_W-1:0]   read_index;

  modport source (output valid, output cmd, output sign_word, output sample_byte,
                  output read_index, input ready);
  modport sink (input valid, input cmd, input sign_word, input sample_byte,
                input read_index, output ready);
endinterface

FILE: hw/rtl/sib_out_if.sv
// ----------------------------------------------------------------------------
// sib_out_if
// Result channel of the challenge sampler.
// ----------------------------------------------------------------------------
interface sib_out_if;
  logic                          valid;
  logic                          ready;
  logic [sib_pkg::STATUS_W-1:0]  status;
  logic [sib_pkg::COEFF_W-1:0]   coeff_value;
  logic                          done_res;

  modport source (output valid, output status, output coeff_value, output done_res,
                  input ready);
  modport sink (input valid, input status, input coeff_value, input done_res,
                output ready);
endinterface

FILE: hw/rtl/sample_in_ball_sampler_core.sv
// ----------------------------------------------------------------------------
// sample_in_ball_sampler_core
// Sparse ternary challenge builder: a front end decodes command words into a
// two-entry queue, a back end shuffles coefficients in a single-write-port store.
// ----------------------------------------------------------------------------
// Timing: the back end handles one command at a time. A sample byte that is
// placed takes a store read plus sign write, then the write at the cursor
// through the one write port; a read waits for the registered store read;
// a rejected or ignored byte and any other word are answered from idle alone.
// A start returns its word at once, then sweeps the store to zero, one entry
// per cycle, before the next command runs; the same sweep follows reset.
// The queue keeps taking words during a sweep until it holds two. Results
// wait in a single output register; while that word is not taken the back
// end holds, and once the queue holds two the command side stalls as well.
module sample_in_ball_sampler_core #(
  parameter int NUM_COEFFS = sib_pkg::NUM_COEFFS_DEF,
  parameter int MODULUS    = sib_pkg::MODULUS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sib_in_if.sink                        in_if,
  sib_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [sib_pkg::WEIGHT_W-1:0]  cfg_wdata
);

  localparam int IDX_W = $clog2(NUM_COEFFS);

  logic                        push;
  sib_pkg::op_t                push_op;
  logic                        q_full;
  logic                        head_valid;
  sib_pkg::op_t                head_op;
  logic                        head_ready;
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [sib_pkg::CODE_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]            ram_raddr;
  logic [sib_pkg::CODE_W-1:0]  ram_rdata;

  sib_front #(
    .NUM_COEFFS (NUM_COEFFS)
  ) u_front (
    .in_if   (in_if),
    .q_full  (q_full),
    .push    (push),
    .push_op (push_op)
  );

  sib_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (head_valid && head_ready),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  sib_back #(
    .NUM_COEFFS (NUM_COEFFS),
    .MODULUS    (MODULUS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .op_valid  (head_valid),
    .op        (head_op),
    .op_ready  (head_ready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_if    (out_if)
  );

  sib_ram #(
    .WIDTH (sib_pkg::CODE_W),
    .DEPTH (NUM_COEFFS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: hw/rtl/sib_ram.sv
// ----------------------------------------------------------------------------
// sib_ram
// Generic memory, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sib_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: hw/rtl/sib_front.sv
// ----------------------------------------------------------------------------
// sib_front
// Accepts command words and classifies them into queue operations.
// ----------------------------------------------------------------------------
module sib_front #(
  parameter int NUM_COEFFS = sib_pkg::NUM_COEFFS_DEF
) (
  sib_in_if.sink          in_if,
  input  logic            q_full,
  output logic            push,
  output sib_pkg::op_t    push_op
);

  localparam int CUR_W = $clog2(NUM_COEFFS + 1);
  localparam int CMP_W = (CUR_W > sib_pkg::BYTE_W) ? CUR_W : sib_pkg::BYTE_W;

  assign in_if.ready = !q_full;
  assign push        = in_if.valid && !q_full;

  always_comb begin
    push_op.sign_word   = in_if.sign_word;
    push_op.sample_byte = in_if.sample_byte;
    push_op.read_index  = in_if.read_index;
    push_op.ridx_ok     = CMP_W'(in_if.read_index) < CMP_W'(NUM_COEFFS);
    case (in_if.cmd)
      sib_pkg::CMD_START: push_op.kind = sib_pkg::OP_START;
      sib_pkg::CMD_BYTE:  push_op.kind = sib_pkg::OP_BYTE;
      sib_pkg::CMD_READ:  push_op.kind = sib_pkg::OP_READ;
      default:            push_op.kind = sib_pkg::OP_NOP;
    endcase
  end

endmodule

FILE: hw/rtl/sib_queue.sv
// ----------------------------------------------------------------------------
// sib_queue
// Two-entry operation queue between the front and back ends.
// ----------------------------------------------------------------------------
module sib_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sib_pkg::op_t  push_op,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output sib_pkg::op_t  head_op
);

  sib_pkg::op_t q_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_op    = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

FILE: hw/rtl/sib_back.sv
// ----------------------------------------------------------------------------
// sib_back
// Executes queued operations on the coefficient store and holds the result word.
// ----------------------------------------------------------------------------
module sib_back #(
  parameter int NUM_COEFFS = sib_pkg::NUM_COEFFS_DEF,
  parameter int MODULUS    = sib_pkg::MODULUS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sib_pkg::WEIGHT_W-1:0]      cfg_wdata,
  input  logic                              op_valid,
  input  sib_pkg::op_t                      op,
  output logic                              op_ready,
  output logic                              ram_we,
  output logic [$clog2(NUM_COEFFS)-1:0]     ram_waddr,
  output logic [sib_pkg::CODE_W-1:0]        ram_wdata,
  output logic [$clog2(NUM_COEFFS)-1:0]     ram_raddr,
  input  logic [sib_pkg::CODE_W-1:0]        ram_rdata,
  sib_out_if.source                         out_if
);

  localparam int IDX_W = $clog2(NUM_COEFFS);
  localparam int CUR_W = $clog2(NUM_COEFFS + 1);
  localparam int CMP_W = (CUR_W > sib_pkg::BYTE_W) ? CUR_W : sib_pkg::BYTE_W;
  localparam logic [CUR_W-1:0] CUR_END = CUR_W'(NUM_COEFFS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_COEFFS - 1);
  localparam logic [sib_pkg::COEFF_W-1:0] QM1 = sib_pkg::COEFF_W'(MODULUS - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SWAP,
    S_READ
  } state_t;

  state_t                          state_r, state_nxt;
  logic [IDX_W-1:0]                clr_cnt_r, clr_cnt_nxt;
  logic [CUR_W-1:0]                cursor_r, cursor_nxt;
  logic [sib_pkg::SIGN_W-1:0]      sign_r, sign_nxt;
  logic [sib_pkg::SCUR_W-1:0]      scur_r, scur_nxt;
  logic [sib_pkg::WEIGHT_W-1:0]    weight_r;
  logic [IDX_W-1:0]                cur_addr_r, cur_addr_nxt;
  logic                            same_r, same_nxt;
  logic                            rd_ok_r, rd_ok_nxt;
  logic                            res_valid_r, res_valid_nxt;
  sib_pkg::status_t                res_status_r, res_status_nxt;
  logic [sib_pkg::COEFF_W-1:0]     res_value_r, res_value_nxt;
  logic                            res_done_r, res_done_nxt;

  logic                            pop;
  logic                            acc_pop;
  logic                            load;
  sib_pkg::status_t                ld_status;
  logic [sib_pkg::COEFF_W-1:0]     ld_value;
  logic [sib_pkg::WEIGHT_W-1:0]    wcap;
  logic [sib_pkg::CODE_W-1:0]      sign_code;

  assign out_if.valid       = res_valid_r;
  assign out_if.status      = res_status_r;
  assign out_if.coeff_value = res_value_r;
  assign out_if.done_res    = res_done_r;

  assign wcap      = (weight_r > sib_pkg::SIGN_CNT) ? sib_pkg::SIGN_CNT : weight_r;
  assign sign_code = sign_r[scur_r] ? sib_pkg::CODE_MINUS : sib_pkg::CODE_PLUS;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cursor_nxt    = cursor_r;
    sign_nxt      = sign_r;
    scur_nxt      = scur_r;
    cur_addr_nxt  = cur_addr_r;
    same_nxt      = same_r;
    rd_ok_nxt     = rd_ok_r;
    res_valid_nxt = res_valid_r;
    res_status_nxt = res_status_r;
    res_value_nxt = res_value_r;
    res_done_nxt  = res_done_r;
    ram_we        = 1'b0;
    ram_waddr     = clr_cnt_r;
    ram_wdata     = sib_pkg::CODE_ZERO;
    ram_raddr     = IDX_W'(op.read_index);
    load          = 1'b0;
    acc_pop       = 1'b0;
    ld_status     = sib_pkg::ST_IGNORED;
    ld_value      = '0;

    op_ready = (state_r == S_IDLE) && (!res_valid_r || out_if.ready);
    pop      = op_ready && op_valid;

    if (res_valid_r && out_if.ready) begin
      res_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        if (clr_cnt_r == IDX_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (pop) begin
          case (op.kind)
            sib_pkg::OP_START: begin
              cursor_nxt  = CUR_END - CUR_W'(wcap);
              sign_nxt    = op.sign_word;
              scur_nxt    = '0;
              clr_cnt_nxt = '0;
              state_nxt   = S_CLEAR;
              load        = 1'b1;
              ld_status   = sib_pkg::ST_STARTED;
            end
            sib_pkg::OP_BYTE: begin
              load = 1'b1;
              if (cursor_r >= CUR_END) begin
                ld_status = sib_pkg::ST_IGNORED;
              end else if (CMP_W'(op.sample_byte) > CMP_W'(cursor_r)) begin
                ld_status = sib_pkg::ST_REJECTED;
              end else begin
                acc_pop      = 1'b1;
                ld_status    = sib_pkg::ST_ACCEPTED;
                ram_we       = 1'b1;
                ram_waddr    = IDX_W'(op.sample_byte);
                ram_wdata    = sign_code;
                ram_raddr    = IDX_W'(op.sample_byte);
                cur_addr_nxt = cursor_r[IDX_W-1:0];
                same_nxt     = (CMP_W'(op.sample_byte) == CMP_W'(cursor_r));
                cursor_nxt   = cursor_r + 1'b1;
                scur_nxt     = scur_r + 1'b1;
                state_nxt    = S_SWAP;
              end
            end
            sib_pkg::OP_READ: begin
              ram_raddr = IDX_W'(op.read_index);
              rd_ok_nxt = op.ridx_ok;
              state_nxt = S_READ;
            end
            default: begin
              load      = 1'b1;
              ld_status = sib_pkg::ST_IGNORED;
            end
          endcase
        end
      end
      S_SWAP: begin
        ram_we    = !same_r;
        ram_waddr = cur_addr_r;
        ram_wdata = ram_rdata;
        state_nxt = S_IDLE;
      end
      S_READ: begin
        load      = 1'b1;
        ld_status = sib_pkg::ST_READ;
        if (rd_ok_r) begin
          case (ram_rdata)
            sib_pkg::CODE_PLUS:  ld_value = sib_pkg::COEFF_W'(1);
            sib_pkg::CODE_MINUS: ld_value = QM1;
            default:             ld_value = '0;
          endcase
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load) begin
      res_valid_nxt  = 1'b1;
      res_status_nxt = ld_status;
      res_value_nxt  = ld_value;
      res_done_nxt   = (cursor_nxt >= CUR_END);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      cursor_r    <= CUR_END;
      sign_r      <= '0;
      scur_r      <= '0;
      weight_r    <= sib_pkg::WEIGHT_RST;
      res_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      cursor_r     <= cursor_nxt;
      sign_r       <= sign_nxt;
      scur_r       <= scur_nxt;
      cur_addr_r   <= cur_addr_nxt;
      same_r       <= same_nxt;
      rd_ok_r      <= rd_ok_nxt;
      res_valid_r  <= res_valid_nxt;
      res_status_r <= res_status_nxt;
      res_value_r  <= res_value_nxt;
      res_done_r   <= res_done_nxt;
      if (cfg_we) begin
        weight_r <= cfg_wdata;
      end
    end
  end

  a_swap_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWAP |=> state_r == S_IDLE)
    else $error("swap write did not finish in one cycle");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= CUR_END)
    else $error("cursor beyond end of store");

  a_accept_step: assert property (@(posedge clk) disable iff (!rst_n)
    acc_pop |=> cursor_r == $past(cursor_r) + 1'b1)
    else $error("accepted byte did not advance cursor by one");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && op.kind == sib_pkg::OP_START |=> state_r == S_CLEAR && clr_cnt_r == '0)
    else $error("start did not begin a clear sweep");

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> !res_valid_r)
    else $error("read result would overwrite a pending word");

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sample-in-ball challenge sampler. A directed
// table covers reset, the weight extremes and the ignore and reject cases.
// Random build phases follow: random weights, mostly well-formed byte streams
// with random content, reads of placed positions, and some noise and broken
// sequences. Results are checked against the table or an in-bench predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sib_pkg::*;

  localparam int NUM_COEFFS = NUM_COEFFS_DEF;
  localparam int MODULUS    = MODULUS_DEF;
  localparam int IDX_W      = $clog2(NUM_COEFFS);
  localparam int RAND_ITEMS = 450;
  localparam int DRAIN      = NUM_COEFFS + 40;
  localparam int LIMIT      = 200000;
  localparam int LONG_HOLD  = 200;
  localparam int N_DIR      = 24;

  localparam logic [CMD_W-1:0]   CMD_UNUSED = 2'd3;
  localparam logic [COEFF_W-1:0] Q_MINUS_1  = COEFF_W'(MODULUS - 1);

  typedef struct packed {
    status_t              status;
    logic [COEFF_W-1:0]   coeff;
    logic                 done;
  } result_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [WEIGHT_W-1:0]  cfg_val;
    logic [CMD_W-1:0]     cmd;
    logic [SIGN_W-1:0]    sign_word;
    logic [BYTE_W-1:0]    sample_byte;
    logic [BYTE_W-1:0]    read_index;
    logic                 typed;
    result_t              fixed;
  } stim_row_t;

  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    '{1'b0, 7'd0,   CMD_BYTE,   64'd0, 8'h00, 8'h00, 1'b1, '{ST_IGNORED, 23'd0, 1'b1}},
    '{1'b0, 7'd0,   CMD_READ,   64'd0, 8'h00, 8'hff, 1'b1, '{ST_READ, 23'd0, 1'b1}},
    '{1'b0, 7'd0,   CMD_UNUSED, 64'd0, 8'hff, 8'hff, 1'b1, '{ST_IGNORED, 23'd0, 1'b1}},
    '{1'b0, 7'd0,   CMD_START,  '1,    8'h00, 8'h00, 1'b1, '{ST_STARTED, 23'd0, 1'b0}},
    '{1'b0, 7'd0,   CMD_BYTE,   64'd0, 8'hff, 8'h00, 1'b1, '{ST_REJECTED, 23'd0, 1'b0}},
    '{1'b0, 7'd0,   CMD_BYTE,   64'd0, 8'h00, 8'h00, 1'b0, '0},
    '{1'b0, 7'd0,   CMD_READ,   64'd0, 8'h00, 8'h00, 1'b1, '{ST_READ, Q_MINUS_1, 1'b0}},
    '{1'b0, 7'd0,   CMD_BYTE,   64'd0, 8'd218, 8'h00, 1'b0, '0},
    '{1'b0, 7'd0,   CMD_READ,   64'd0, 8'h00, 8'd218, 1'b0, '0},
    '{1'b0, 7'd0,   CMD_READ,   64'd0, 8'h00, 8'd217, 1'b0, '0},
    '{1'b0, 7'd0,   CMD_UNUSED, 64'd0, 8'h00, 8'h00, 1'b1, '{ST_IGNORED, 23'd0, 1'b0}},
    '{1'b1, 7'd0,   CMD_START,  64'd0, 8'h00, 8'h00, 1'b0, '0},
    '{1'b0, 7'd0,   CMD_START,  64'd0, 8'h00, 8'h00, 1'b1, '{ST_STARTED, 23'd0, 1'b1}},
    '{1'b0, 7'd0,   CMD_BYTE,   64'd0, 8'h07, 8'h00, 1'b1, '{ST_IGNORED, 23'd0, 1'b1}},
    '{1'b0, 7'd0,   CMD_READ,   64'd0, 8'h00, 8'hff, 1'b1, '{ST_READ, 23'd0, 1'b1}},
    '{1'b1, 7'd1,   CMD_START,  64'd0, 8'h00, 8'h00, 1'b0, '0},
    '{1'b0, 7'd0,   CMD_START,  64'd0, 8'h00, 8'h00, 1'b1, '{ST_STARTED, 23'd0, 1'b0}},
    '{1'b0, 7'd0,   CMD_BYTE,   64'd0, 8'hff, 8'h00, 1'b0, '0},
    '{1'b0, 7'd0,   CMD_READ,   64'd0, 8'h00, 8'hff, 1'b0, '0},
    '{1'b0, 7'd0,   CMD_BYTE,   64'd0, 8'h80, 8'h00, 1'b1, '{ST_IGNORED, 23'd0, 1'b1}},
    '{1'b1, 7'd127, CMD_START,  64'd0, 8'h00, 8'h00, 1'b0, '0},
    '{1'b0, 7'd0,   CMD_START,  {32{2'b10}}, 8'h00, 8'h00, 1'b1,
      '{ST_STARTED, 23'd0, 1'b0}},
    '{1'b0, 7'd0,   CMD_BYTE,   64'd0, 8'h00, 8'h00, 1'b0, '0},
    '{1'b0, 7'd0,   CMD_READ,   64'd0, 8'h00, 8'h00, 1'b0, '0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [WEIGHT_W-1:0] cfg_wdata;

  sib_in_if  in_ch ();
  sib_out_if out_ch ();

  sample_in_ball_sampler_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // challenge model state
  logic [CODE_W-1:0]   chal_coeffs [NUM_COEFFS];
  int unsigned         place_cursor;
  logic [SIGN_W-1:0]   sign_reg;
  logic [SCUR_W-1:0]   sign_ptr;
  logic [WEIGHT_W-1:0] weight_reg;

  result_t pending_results [$];
  int      n_errors;
  int      n_checked;
  int      n_words;
  int      n_counted;
  int      n_builds;
  int      cycle_count;
  bit      quiet;
  bit      long_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("FAIL sample_in_ball_sampler_core");
      $finish;
    end
  end

  function automatic result_t predict_challenge_step(input logic [CMD_W-1:0] cmd,
      input logic [SIGN_W-1:0] sw, input logic [BYTE_W-1:0] b,
      input logic [BYTE_W-1:0] ridx);
    result_t     r;
    int unsigned w;
    r.status = ST_IGNORED;
    r.coeff  = '0;
    case (cmd)
      CMD_START: begin
        w = 32'(weight_reg);
        if (w > 32'(SIGN_CNT)) w = 32'(SIGN_CNT);
        foreach (chal_coeffs[i]) chal_coeffs[i] = CODE_ZERO;
        sign_reg     = sw;
        sign_ptr     = '0;
        place_cursor = NUM_COEFFS - w;
        r.status     = ST_STARTED;
      end
      CMD_BYTE: begin
        if (place_cursor < NUM_COEFFS) begin
          if (32'(b) > place_cursor) begin
            r.status = ST_REJECTED;
          end else begin
            chal_coeffs[place_cursor[IDX_W-1:0]] = chal_coeffs[b];
            chal_coeffs[b] = sign_reg[sign_ptr] ? CODE_MINUS : CODE_PLUS;
            place_cursor++;
            sign_ptr++;
            r.status = ST_ACCEPTED;
          end
        end
      end
      CMD_READ: begin
        case (chal_coeffs[ridx])
          CODE_PLUS:  r.coeff = 23'd1;
          CODE_MINUS: r.coeff = Q_MINUS_1;
          default:    r.coeff = '0;
        endcase
        r.status = ST_READ;
      end
      default: ;
    endcase
    r.done = (place_cursor >= NUM_COEFFS);
    return r;
  endfunction

  // offer one word after a random gap; the expectation is queued at acceptance
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SIGN_W-1:0] sw,
      input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] ridx, output result_t pred,
      input bit use_fixed = 1'b0, input result_t fixed = '0);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.sign_word   <= sw;
    in_ch.sample_byte <= b;
    in_ch.read_index  <= ridx;
    do @(posedge clk); while (!in_ch.ready);
    pred = predict_challenge_step(cmd, sw, b, ridx);
    pending_results.push_back(use_fixed ? fixed : pred);
    n_words++;
    if (pred.status != ST_IGNORED) n_counted++;
    if (pred.status == ST_STARTED) n_builds++;
  endtask

  task automatic write_weight(input logic [WEIGHT_W-1:0] w);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    // a start may still be sweeping the store
    repeat (DRAIN) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we     <= 1'b0;
    weight_reg  = w;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int hold;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        hold      = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        hold = quiet ? 0 : $urandom_range(0, 7);
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: status %0d", out_ch.status);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          n_errors++;
        end
        if (out_ch.coeff_value !== want.coeff) begin
          $error("coeff_value: expected %0d, got %0d", want.coeff, out_ch.coeff_value);
          n_errors++;
        end
        if (out_ch.done_res !== want.done) begin
          $error("done_res: expected %0d, got %0d", want.done, out_ch.done_res);
          n_errors++;
        end
      end
    end
  end

  initial begin
    result_t             res;
    stim_row_t           row;
    logic [WEIGHT_W-1:0] w;
    logic [BYTE_W-1:0]   sb;
    logic [BYTE_W-1:0]   ri;
    logic [BYTE_W-1:0]   placed_pos [$];
    int                  pick;
    int                  phase;
    bit                  broken;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_START;
    in_ch.sign_word   <= '0;
    in_ch.sample_byte <= '0;
    in_ch.read_index  <= '0;
    foreach (chal_coeffs[i]) chal_coeffs[i] = CODE_ZERO;
    place_cursor = NUM_COEFFS;
    sign_reg     = '0;
    sign_ptr     = '0;
    weight_reg   = WEIGHT_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < N_DIR; k++) begin
      row = DIR_ROWS[k];
      if (row.is_cfg) write_weight(row.cfg_val);
      else send_word(row.cmd, row.sign_word, row.sample_byte, row.read_index, res,
                     row.typed, row.fixed);
    end

    phase = 0;
    while (n_counted < RAND_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       w = 7'd0;
        1:       w = 7'd1;
        2:       w = 7'd64;
        3:       w = 7'd65;
        4:       w = 7'd127;
        default: w = WEIGHT_W'($urandom_range(1, 64));
      endcase
      if (phase == 2) w = 7'd64;
      write_weight(w);
      quiet = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        quiet     = 1'b0;
        long_hold = 1'b1;
      end
      send_word(CMD_START, {$urandom, $urandom}, BYTE_W'($urandom), BYTE_W'($urandom),
                res);
      placed_pos.delete();
      broken = 1'b0;
      while (place_cursor < NUM_COEFFS && !broken) begin
        pick = $urandom_range(0, 99);
        res  = '0;
        if (pick < 70) begin
          sb = BYTE_W'($urandom_range(0, place_cursor));
          send_word(CMD_BYTE, {$urandom, $urandom}, sb, BYTE_W'($urandom), res);
        end else if (pick < 82) begin
          sb = BYTE_W'($urandom);
          send_word(CMD_BYTE, {$urandom, $urandom}, sb, BYTE_W'($urandom), res);
        end else if (pick < 92) begin
          send_word(CMD_READ, {$urandom, $urandom}, BYTE_W'($urandom), BYTE_W'($urandom),
                    res);
        end else if (pick < 95) begin
          send_word(CMD_UNUSED, {$urandom, $urandom}, BYTE_W'($urandom),
                    BYTE_W'($urandom), res);
        end else if (pick < 97) begin
          send_word(CMD_START, {$urandom, $urandom}, BYTE_W'($urandom), BYTE_W'($urandom),
                    res);
          placed_pos.delete();
        end else begin
          broken = 1'b1;
        end
        if (res.status == ST_ACCEPTED) placed_pos.push_back(sb);
      end
      repeat ($urandom_range(4, 10)) begin
        pick = $urandom_range(0, 3);
        if (pick < 2 && placed_pos.size() > 0)
          ri = placed_pos[$urandom_range(0, placed_pos.size() - 1)];
        else if (pick < 3)
          ri = BYTE_W'($urandom_range(NUM_COEFFS - 64, NUM_COEFFS - 1));
        else
          ri = BYTE_W'($urandom);
        send_word(CMD_READ, {$urandom, $urandom}, BYTE_W'($urandom), ri, res);
      end
      repeat ($urandom_range(0, 2))
        send_word(CMD_BYTE, {$urandom, $urandom}, BYTE_W'($urandom), BYTE_W'($urandom),
                  res);
      phase++;
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d words in %0d challenge builds over %0d random phases",
             n_words, n_builds, phase);
    $display("checked %0d result words, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("PASS sample_in_ball_sampler_core");
    end else begin
      $display("FAIL sample_in_ball_sampler_core");
    end
    $finish;
  end

endmodule
